// File: rtl/bvm_pkg.sv
// shared types and constants of the battery voltage monitor
`timescale 1ns / 1ps

package bvm_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int MV_W       = 14;
    localparam int PCT_W      = 7;
    localparam int GAIN_W     = 16;
    localparam int OFS_W      = 12;
    localparam int WEIGHT_W   = 16;
    localparam int RISE_W     = 10;
    localparam int VAL_W      = 30;          // filter value, Q14.16
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // divider widths
    localparam int NUM_W  = 22;
    localparam int DEN_W  = 15;
    localparam int QUOT_W = 7;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_MV    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_MV      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF_MV    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RISE_MV      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_PREVIEW_MODE = 3'd6;

    // configuration reset values
    localparam logic [GAIN_W-1:0]   RST_SCALE_GAIN = 16'd8192;
    localparam logic [OFS_W-1:0]    RST_OFFSET_MV  = 12'd0;
    localparam logic [MV_W-1:0]     RST_FULL_MV    = 14'd4200;
    localparam logic [MV_W-1:0]     RST_CUTOFF_MV  = 14'd3300;
    localparam logic [WEIGHT_W-1:0] RST_SMOOTHING  = 16'd3277;
    localparam logic [RISE_W-1:0]   RST_RISE_MV    = 10'd30;

    // arithmetic constants
    localparam logic [MV_W-1:0]  MV_MAX     = 14'd16383;
    localparam logic [MV_W-1:0]  MV_FLOOR   = 14'd1000;
    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;
    localparam logic [MUL_B_W-1:0] K_WIN_MID = 17'd50;
    localparam logic [MUL_B_W-1:0] K_WIN_LO  = 17'd49;
    localparam logic [MUL_B_W-1:0] K_PCT     = 17'd200;
    localparam logic [MUL_B_W-1:0] K_ONE_Q16 = 17'h10000;

    // history unit status back to the sequencer
    typedef struct packed {
        logic done;
        logic charging;
    } t_hist_res;

endpackage

// File: rtl/bvm_mul.sv
// shared registered multiplier of the battery voltage monitor
`timescale 1ns / 1ps

module bvm_mul (
    input  logic                         i_clk,
    input  logic [bvm_pkg::MUL_A_W-1:0]  i_a,
    input  logic [bvm_pkg::MUL_B_W-1:0]  i_b,
    output logic [bvm_pkg::MUL_P_W-1:0]  o_p
);
    import bvm_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    // product is registered and ready in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: rtl/bvm_div.sv
// restoring divider for the percent quotient, one quotient bit per cycle
`timescale 1ns / 1ps

module bvm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bvm_pkg::NUM_W-1:0]   i_num,
    input  logic [bvm_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [bvm_pkg::QUOT_W-1:0]  o_quot
);
    import bvm_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(QUOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_q;
    logic              w_fit;

    assign w_fit = (r_rem >= r_dsh);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder, shifted divisor and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NUM_W'({i_den, {(QUOT_W-1){1'b0}}});
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QUOT_W-2:0], w_fit};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/bvm_hist.sv
// raw voltage history ring and rise check for charging detection
`timescale 1ns / 1ps

module bvm_hist #(
    parameter int DEPTH = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bvm_pkg::MV_W-1:0]    i_raw,
    input  logic [bvm_pkg::RISE_W-1:0]  i_rise,
    output bvm_pkg::t_hist_res          o_res
);
    import bvm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SUM_W = MV_W + 2;

    localparam logic [2:0] STEP_WRITE = 3'd5;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    logic [MV_W-1:0]  r_mem [DEPTH];
    logic [MV_W-1:0]  r_rd;
    logic [MV_W-1:0]  r_raw;
    logic [AW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [2:0]       r_step;
    logic             r_busy;
    logic             r_done;
    logic             r_chg;
    logic [SUM_W-1:0] r_nsum;
    logic [SUM_W-1:0] r_osum;
    logic [AW-1:0]    w_addr;
    logic [SUM_W-1:0] w_diff;
    logic [RISE_W+1:0] w_thr;

    function automatic logic [AW-1:0] f_fwd(input logic [AW-1:0] h, input logic [AW:0] k);
        logic [AW+1:0] s;
        s = {2'b00, h} + {1'b0, k};
        if (s >= (AW+2)'(DEPTH)) begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_back(input logic [AW-1:0] h, input logic [AW:0] k);
        logic [AW+1:0] s;
        if ({1'b0, h} >= k) begin
            s = {2'b00, h} - {1'b0, k};
        end else begin
            s = {2'b00, h} + (AW+2)'(DEPTH) - {1'b0, k};
        end
        return s[AW-1:0];
    endfunction

    // read order: two newest before this one, then the three oldest
    always_comb begin
        case (r_step)
            3'd0:    w_addr = f_back(r_head, (AW+1)'(1));
            3'd1:    w_addr = f_back(r_head, (AW+1)'(2));
            3'd2:    w_addr = f_fwd(r_head, (AW+1)'(1));
            3'd3:    w_addr = f_fwd(r_head, (AW+1)'(2));
            3'd4:    w_addr = f_fwd(r_head, (AW+1)'(3));
            default: w_addr = r_head;
        endcase
    end

    // history memory, registered read
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_addr];
        if (r_busy && r_step == STEP_WRITE) begin
            r_mem[r_head] <= r_raw;
        end
    end

    // control: step counter, ring head and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == STEP_WRITE) begin
                    r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                    if (r_fill != FW'(DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_diff = r_nsum - r_osum;
    assign w_thr  = {1'b0, i_rise, 1'b0} + {2'b00, i_rise};

    // sums of the newest and oldest three, verdict at the last step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_raw  <= i_raw;
            r_nsum <= SUM_W'(i_raw);
            r_osum <= '0;
        end else if (r_busy) begin
            if (r_step == 3'd1 || r_step == 3'd2) begin
                r_nsum <= r_nsum + SUM_W'(r_rd);
            end else if (r_step == 3'd3 || r_step == 3'd4 || r_step == STEP_WRITE) begin
                r_osum <= r_osum + SUM_W'(r_rd);
            end
            if (r_step == STEP_LAST) begin
                if (r_fill != FW'(DEPTH)) begin
                    r_chg <= 1'b1;
                end else begin
                    r_chg <= (r_nsum > r_osum) && (w_diff > SUM_W'(w_thr));
                end
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.charging = r_chg;

endmodule

// File: rtl/battery_voltage_monitor_top.sv
// top level of the battery voltage monitor: sequencer, filters and result register
`timescale 1ns / 1ps

// Battery voltage monitor. Each input word carries one ADC sample in millivolts; the
// block scales it by the Q4.12 gain, adds the offset and saturates to 0..16383 mV,
// runs two exponential filters (the second one skips a single sample outside +/-2
// percent), checks a raw history of HISTORY_DEPTH samples for a charging rise and
// counts LOW_COUNT low samples toward a sleep request. One result word comes out per
// sample. All products go through one shared registered 30x17 multiplier under a
// small sequencer, the history sits in a single-port memory read one entry a cycle,
// and the percent quotient comes from a one-bit-per-cycle divider, which is run only
// when the percent needs it. The first sample after reset skips the filter steps.
// The input is not ready while a sample is in work; a finished result waits in the
// output register while the next sample is accepted. Configuration writes are taken
// at any time and are meant to happen while the block is idle.

module battery_voltage_monitor_top #(
    parameter int HISTORY_DEPTH = 12,
    parameter int LOW_COUNT     = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word: sample_mv[11:0]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bvm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // result word: battery_mv[13:0], percent[20:14], raw_scaled_mv[34:21],
    // sleep_request[35], charging[36]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bvm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bvm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import bvm_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_SCALE = 16'b0000_0000_0000_0010,
        ST_RAW   = 16'b0000_0000_0000_0100,
        ST_R50   = 16'b0000_0000_0000_1000,
        ST_G49   = 16'b0000_0000_0001_0000,
        ST_SOLD  = 16'b0000_0000_0010_0000,
        ST_SNEW  = 16'b0000_0000_0100_0000,
        ST_SUPD  = 16'b0000_0000_1000_0000,
        ST_GNEW  = 16'b0000_0001_0000_0000,
        ST_GUPD  = 16'b0000_0010_0000_0000,
        ST_HIST  = 16'b0000_0100_0000_0000,
        ST_HWAIT = 16'b0000_1000_0000_0000,
        ST_EVAL  = 16'b0001_0000_0000_0000,
        ST_DIVS  = 16'b0010_0000_0000_0000,
        ST_DIVW  = 16'b0100_0000_0000_0000,
        ST_DONE  = 16'b1000_0000_0000_0000
    } t_state;

    localparam int ACC_W = 48;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [GAIN_W-1:0]   r_gain;
    logic [OFS_W-1:0]    r_offset;
    logic [MV_W-1:0]     r_full;
    logic [MV_W-1:0]     r_cutoff;
    logic [WEIGHT_W-1:0] r_weight;
    logic [RISE_W-1:0]   r_rise;
    logic                r_preview;

    // filter and sequencing state
    logic [VAL_W-1:0]    r_smooth;
    logic [VAL_W-1:0]    r_glitch;
    logic                r_first;
    logic                r_gseen;
    logic [2:0]          r_lowcnt;

    // per-sample working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic [MV_W-1:0]     r_raw;
    logic [19:0]         r_r50;
    logic                r_inside;
    logic [MUL_P_W-1:0]  r_acc;
    logic [MV_W-1:0]     r_v;
    logic                r_chg;
    logic                r_sleep;
    logic [MV_W-1:0]     r_batt;
    logic [PCT_W-1:0]    r_pct;

    // output register
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    // unit connections
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    t_hist_res          w_hist;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN_W-1:0]   w_div_den;

    // datapath helpers
    logic [28:0]      w_rnd;
    logic [17:0]      w_sum;
    logic [MV_W-1:0]  w_raw;
    logic [35:0]      w_r50_q;
    logic [35:0]      w_g49;
    logic [35:0]      w_g51;
    logic [ACC_W-1:0] w_filt;
    logic [VAL_W-1:0] w_new;
    logic [VAL_W-1:0] w_sel;
    logic [VAL_W:0]   w_vrnd;
    logic [MV_W-1:0]  w_v;
    logic             w_low;
    logic [2:0]       w_cnt_dec;
    logic [MV_W-1:0]  w_span;
    logic             w_load_out;

    bvm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    bvm_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_HIST),
        .i_raw   (r_raw),
        .i_rise  (r_rise),
        .o_res   (w_hist)
    );

    bvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIVS),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= RST_SCALE_GAIN;
            r_offset  <= RST_OFFSET_MV;
            r_full    <= RST_FULL_MV;
            r_cutoff  <= RST_CUTOFF_MV;
            r_weight  <= RST_SMOOTHING;
            r_rise    <= RST_RISE_MV;
            r_preview <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SCALE_GAIN:   r_gain    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_OFFSET_MV:    r_offset  <= i_cfg_wdata[OFS_W-1:0];
                CFG_FULL_MV:      r_full    <= i_cfg_wdata[MV_W-1:0];
                CFG_CUTOFF_MV:    r_cutoff  <= i_cfg_wdata[MV_W-1:0];
                CFG_SMOOTHING:    r_weight  <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_RISE_MV:      r_rise    <= i_cfg_wdata[RISE_W-1:0];
                CFG_PREVIEW_MODE: r_preview <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_SCALE: begin
                w_mul_a = MUL_A_W'(r_gain);
                w_mul_b = MUL_B_W'(r_sample);
            end
            ST_R50: begin
                w_mul_a = MUL_A_W'(r_raw);
                w_mul_b = K_WIN_MID;
            end
            ST_G49: begin
                w_mul_a = r_glitch;
                w_mul_b = K_WIN_LO;
            end
            ST_SOLD: begin
                w_mul_a = r_smooth;
                w_mul_b = K_ONE_Q16 - {1'b0, r_weight};
            end
            ST_SNEW, ST_GNEW: begin
                w_mul_a = MUL_A_W'(r_raw);
                w_mul_b = {1'b0, r_weight};
            end
            ST_SUPD: begin
                w_mul_a = r_glitch;
                w_mul_b = K_ONE_Q16 - {1'b0, r_weight};
            end
            ST_EVAL: begin
                w_mul_a = MUL_A_W'(r_v - r_cutoff);
                w_mul_b = K_PCT;
            end
            default: ;
        endcase
    end

    // scaling: round the Q4.12 product, add the offset, saturate
    assign w_rnd = {1'b0, w_prod[27:0]} + 29'd2048;
    assign w_sum = {2'b00, w_rnd[27:12]} + {{(18-OFS_W){r_offset[OFS_W-1]}}, r_offset};
    always_comb begin
        if (w_sum[17]) begin
            w_raw = '0;
        end else if (|w_sum[16:14]) begin
            w_raw = MV_MAX;
        end else begin
            w_raw = w_sum[MV_W-1:0];
        end
    end

    // glitch window: 49*g <= 50*raw*2^16 <= 51*g
    assign w_r50_q = {r_r50, 16'b0};
    assign w_g49   = w_prod[35:0];
    assign w_g51   = w_g49 + {5'b0, r_glitch, 1'b0};

    // filter update from the old-value product and the new-sample product
    assign w_filt = ACC_W'(r_acc) + {2'b00, w_prod[29:0], 16'b0} + ACC_W'(32768);
    assign w_new  = w_filt[45:16];

    // selected filter value rounded to millivolts
    assign w_sel  = r_preview ? r_glitch : r_smooth;
    assign w_vrnd = {1'b0, w_sel} + (VAL_W+1)'(32768);
    assign w_v    = w_vrnd[VAL_W] ? MV_MAX : w_vrnd[VAL_W-1:16];

    // low-voltage countdown and percent range
    assign w_low     = (r_v <= r_cutoff) && (r_v > MV_FLOOR);
    assign w_cnt_dec = r_lowcnt - 3'd1;
    assign w_span    = r_full - r_cutoff;
    assign w_div_num = w_prod[NUM_W-1:0] + NUM_W'(w_span);
    assign w_div_den = {w_span, 1'b0};

    assign w_load_out = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_SCALE;
            ST_SCALE: n_state = ST_RAW;
            ST_RAW:   n_state = r_first ? ST_HIST : ST_R50;
            ST_R50:   n_state = ST_G49;
            ST_G49:   n_state = ST_SOLD;
            ST_SOLD:  n_state = ST_SNEW;
            ST_SNEW:  n_state = ST_SUPD;
            ST_SUPD:  n_state = ST_GNEW;
            ST_GNEW:  n_state = ST_GUPD;
            ST_GUPD:  n_state = ST_HIST;
            ST_HIST:  n_state = ST_HWAIT;
            ST_HWAIT: if (w_hist.done) n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_v >= MV_FLOOR && r_full > r_cutoff && r_v > r_cutoff
                    && r_v < r_full) begin
                    n_state = ST_DIVS;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIVS:  n_state = ST_DIVW;
            ST_DIVW:  if (w_div_done) n_state = ST_DONE;
            ST_DONE:  if (w_load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer state, filters and per-sample registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_first  <= 1'b1;
            r_gseen  <= 1'b0;
            r_lowcnt <= 3'(LOW_COUNT);
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_sample <= s_axis_tdata[SAMPLE_W-1:0];
                end
                ST_RAW: begin
                    r_raw <= w_raw;
                    if (r_first) begin
                        r_smooth <= {r_full, 16'b0};
                        r_glitch <= {r_full, 16'b0};
                        r_first  <= 1'b0;
                    end
                end
                ST_G49: begin
                    r_r50 <= w_prod[19:0];
                end
                ST_SOLD: begin
                    r_inside <= (w_r50_q >= w_g49) && (w_r50_q <= w_g51);
                end
                ST_SNEW: begin
                    r_acc <= w_prod;
                end
                ST_SUPD: begin
                    r_smooth <= w_new;
                end
                ST_GNEW: begin
                    r_acc <= w_prod;
                end
                ST_GUPD: begin
                    if (r_inside || r_gseen) begin
                        r_glitch <= w_new;
                        r_gseen  <= 1'b0;
                    end else begin
                        r_gseen <= 1'b1;
                    end
                end
                ST_HWAIT: begin
                    r_v   <= w_v;
                    r_chg <= w_hist.charging;
                end
                ST_EVAL: begin
                    // sleep countdown
                    r_sleep <= 1'b0;
                    if (w_low) begin
                        if (w_cnt_dec == 3'd0) begin
                            r_sleep  <= !(r_preview && r_chg);
                            r_lowcnt <= 3'(LOW_COUNT);
                        end else begin
                            r_lowcnt <= w_cnt_dec;
                        end
                    end else begin
                        r_lowcnt <= 3'(LOW_COUNT);
                    end
                    // battery and percent outside the linear range
                    if (r_v < MV_FLOOR) begin
                        r_batt <= '0;
                        r_pct  <= PCT_FULL;
                    end else begin
                        r_batt <= r_v;
                        if (r_full <= r_cutoff) begin
                            r_pct <= (r_v > r_cutoff) ? PCT_FULL : PCT_EMPTY;
                        end else if (r_v <= r_cutoff) begin
                            r_pct <= PCT_EMPTY;
                        end else begin
                            r_pct <= PCT_FULL;
                        end
                    end
                end
                ST_DIVW: begin
                    if (w_div_done) begin
                        r_pct <= (w_quot > PCT_FULL) ? PCT_FULL : w_quot;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_data <= {3'b000, r_chg, r_sleep, r_raw, r_pct, r_batt};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
